FILE: src/gda_pkg.sv
// Shared types and constants for the Gregorian date adder with weekday.
package gda_pkg;

   // Last year the result can reach; later dates saturate to its Dec 31
   localparam logic [13:0] YearMax   = 14'd16383;
   localparam logic [8:0]  EraYears  = 9'd400;
   localparam logic [3:0]  MonthDec  = 4'd12;

   // Configuration register indexes
   localparam logic [1:0] RegRefDay     = 2'd0;
   localparam logic [1:0] RegRefMonth   = 2'd1;
   localparam logic [1:0] RegRefYear    = 2'd2;
   localparam logic [1:0] RegRefWeekday = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REF_MOD,
      ST_REF_RED,
      ST_START_MOD,
      ST_WALK,
      ST_TGT_KEY,
      ST_TGT_RED,
      ST_FINISH
   } gda_state_type;

   // One input item
   typedef struct packed {
      logic [15:0] days_to_add;
      logic [13:0] start_year;
      logic [4:0]  start_day;
      logic [3:0]  start_month;
   } gda_item_type;

   // Reference date registers
   typedef struct packed {
      logic [2:0]  weekday;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } gda_ref_type;

   // One result item
   typedef struct packed {
      logic [2:0]  weekday;
      logic [13:0] new_year;
      logic [4:0]  new_day;
      logic [3:0]  new_month;
   } gda_result_type;

   // Handshake between the wrapper and the sequencer
   typedef struct packed {
      logic idle;
      logic res_valid;
   } gda_status_type;

endpackage

FILE: src/gda_core.sv
// Sequencer and shared subtractor that compute the new date and its weekday.
module gda_core
   import gda_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  gda_item_type   item,
   input  gda_ref_type    refs,
   input  logic           slot_free,
   output gda_status_type status,
   output gda_result_type result
);

   // Leap year from the year modulo 400
   function automatic logic is_leap(input logic [8:0] c);
      is_leap = (c[1:0] == 2'd0) && (c != 9'd100) && (c != 9'd200) && (c != 9'd300);
   endfunction

   // Days in a month
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
      logic [4:0] len;
      len = 5'd31;
      case (m)
         4'd2:                       len = lp ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
         default:                    len = 5'd31;
      endcase
      month_len = len;
   endfunction

   function automatic logic [3:0] clamp_month(input logic [3:0] m);
      if (m == 4'd0)
         clamp_month = 4'd1;
      else if (m > MonthDec)
         clamp_month = MonthDec;
      else
         clamp_month = m;
   endfunction

   function automatic logic [4:0] clamp_day(input logic [4:0] d, input logic [4:0] len);
      if (d == 5'd0)
         clamp_day = 5'd1;
      else if (d > len)
         clamp_day = len;
      else
         clamp_day = d;
   endfunction

   // Day number modulo 7 up to a multiple of 7: eras are whole weeks and a
   // year of 365 days moves the weekday by one. Result stays below 896.
   function automatic logic [9:0] day_key(input logic [8:0] c, input logic [3:0] m,
                                          input logic [4:0] d);
      logic [8:0] yoe;
      logic [3:0] mp;
      logic [8:0] cum;
      logic [1:0] q100;
      if (m <= 4'd2) begin
         yoe = (c == 9'd0) ? (EraYears - 9'd1) : (c - 9'd1);
         mp  = m + 4'd9;
      end else begin
         yoe = c;
         mp  = m - 4'd3;
      end
      case (mp)
         4'd0:    cum = 9'd0;
         4'd1:    cum = 9'd31;
         4'd2:    cum = 9'd61;
         4'd3:    cum = 9'd92;
         4'd4:    cum = 9'd122;
         4'd5:    cum = 9'd153;
         4'd6:    cum = 9'd184;
         4'd7:    cum = 9'd214;
         4'd8:    cum = 9'd245;
         4'd9:    cum = 9'd275;
         4'd10:   cum = 9'd306;
         4'd11:   cum = 9'd337;
         default: cum = 9'd0;
      endcase
      if (yoe >= 9'd300)
         q100 = 2'd3;
      else if (yoe >= 9'd200)
         q100 = 2'd2;
      else if (yoe >= 9'd100)
         q100 = 2'd1;
      else
         q100 = 2'd0;
      day_key = {1'b0, yoe} + {3'b0, yoe[8:2]} - {8'b0, q100} + {1'b0, cum}
                + {5'b0, d} - 10'd1;
   endfunction

   gda_state_type state_ff, state_in;
   logic [13:0]   x_ff, x_in;       // modulo-400 scratch
   logic [13:0]   y_ff, y_in;       // current year
   logic [8:0]    c_ff, c_in;       // current year modulo 400
   logic [3:0]    m_ff, m_in;
   logic [4:0]    d_ff, d_in;
   logic [15:0]   rem_ff, rem_in;   // days still to walk
   logic [9:0]    k_ff, k_in;       // weekday key being reduced
   logic [2:0]    sh_ff, sh_in;     // reduction step
   logic [2:0]    rk_ff, rk_in;     // reference key modulo 7
   logic [2:0]    wd_ff, wd_in;

   // Shared subtractor
   logic [15:0] sub_a, sub_b;
   logic [16:0] sub_res;
   logic        borrow;

   // Helpers
   logic [8:0]  ref_c;
   logic [3:0]  ref_m;
   logic [4:0]  ref_d;
   logic [3:0]  st_m;
   logic [4:0]  left_p1;
   logic [9:0]  k_next;
   logic [2:0]  ref_wd;
   logic [4:0]  wsum;

   assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow  = sub_res[16];

   // Operand selection for the shared subtractor
   always_comb begin
      sub_a = {2'b0, x_ff};
      sub_b = {7'b0, EraYears};
      case (state_ff)
         ST_REF_RED, ST_TGT_RED: begin
            sub_a = {6'b0, k_ff};
            sub_b = {6'b0, 10'(10'd7 << sh_ff)};
         end
         ST_WALK: begin
            sub_a = rem_ff;
            sub_b = {11'b0, left_p1};
         end
         default: begin
            sub_a = {2'b0, x_ff};
            sub_b = {7'b0, EraYears};
         end
      endcase
   end

   assign ref_c   = x_ff[8:0];
   assign ref_m   = clamp_month(refs.month);
   assign ref_d   = clamp_day(refs.day, month_len(ref_m, is_leap(ref_c)));
   assign st_m    = clamp_month(m_ff);
   assign left_p1 = month_len(m_ff, is_leap(c_ff)) - d_ff + 5'd1;
   assign k_next  = borrow ? k_ff : sub_res[9:0];
   assign ref_wd  = (refs.weekday == 3'd7) ? 3'd0 : refs.weekday;
   // target key minus reference key plus reference weekday, below 21
   assign wsum    = {2'b0, k_next[2:0]} + 5'd7 - {2'b0, rk_ff} + {2'b0, ref_wd};

   // Next state and datapath
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      c_in     = c_ff;
      m_in     = m_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      k_in     = k_ff;
      sh_in    = sh_ff;
      rk_in    = rk_ff;
      wd_in    = wd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               m_in     = item.start_month;
               d_in     = item.start_day;
               y_in     = item.start_year;
               rem_in   = item.days_to_add;
               x_in     = refs.year;
               state_in = ST_REF_MOD;
            end
         end
         // reference year modulo 400, then clamp and key of the reference date
         ST_REF_MOD: begin
            if (!borrow) begin
               x_in = sub_res[13:0];
            end else begin
               k_in     = day_key(ref_c, ref_m, ref_d);
               sh_in    = 3'd6;
               state_in = ST_REF_RED;
            end
         end
         ST_REF_RED: begin
            k_in = k_next;
            if (sh_ff == 3'd0) begin
               rk_in    = k_next[2:0];
               x_in     = y_ff;
               state_in = ST_START_MOD;
            end else begin
               sh_in = sh_ff - 3'd1;
            end
         end
         // start year modulo 400, then clamp the start date
         ST_START_MOD: begin
            if (!borrow) begin
               x_in = sub_res[13:0];
            end else begin
               c_in     = x_ff[8:0];
               m_in     = st_m;
               d_in     = clamp_day(d_ff, month_len(st_m, is_leap(x_ff[8:0])));
               state_in = ST_WALK;
            end
         end
         // one month per cycle
         ST_WALK: begin
            if (borrow) begin
               d_in     = d_ff + rem_ff[4:0];
               state_in = ST_TGT_KEY;
            end else begin
               rem_in = sub_res[15:0];
               d_in   = 5'd1;
               if (m_ff == MonthDec) begin
                  if (y_ff == YearMax) begin
                     d_in     = 5'd31;
                     state_in = ST_TGT_KEY;
                  end else begin
                     y_in = y_ff + 14'd1;
                     c_in = (c_ff == EraYears - 9'd1) ? 9'd0 : c_ff + 9'd1;
                     m_in = 4'd1;
                  end
               end else begin
                  m_in = m_ff + 4'd1;
               end
            end
         end
         ST_TGT_KEY: begin
            k_in     = day_key(c_ff, m_ff, d_ff);
            sh_in    = 3'd6;
            state_in = ST_TGT_RED;
         end
         ST_TGT_RED: begin
            k_in = k_next;
            if (sh_ff == 3'd0) begin
               if (wsum >= 5'd14)
                  wd_in = 3'(wsum - 5'd14);
               else if (wsum >= 5'd7)
                  wd_in = 3'(wsum - 5'd7);
               else
                  wd_in = wsum[2:0];
               state_in = ST_FINISH;
            end else begin
               sh_in = sh_ff - 3'd1;
            end
         end
         ST_FINISH: begin
            if (slot_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      c_ff   <= c_in;
      m_ff   <= m_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      k_ff   <= k_in;
      sh_ff  <= sh_in;
      rk_ff  <= rk_in;
      wd_ff  <= wd_in;
   end

   assign status.idle      = (state_ff == ST_IDLE);
   assign status.res_valid = (state_ff == ST_FINISH);
   assign result.new_month = m_ff;
   assign result.new_day   = d_ff;
   assign result.new_year  = y_ff;
   assign result.weekday   = wd_ff;

endmodule

FILE: src/gregorian_date_add_weekday.sv
// Top level: stream ports, reference date registers and the result register.
//
// Adds a day count to a Gregorian date and gives the resulting date and its
// weekday (0 Sunday .. 6 Saturday), counted from a reference date and weekday
// held in four writable registers. Out-of-range months and days are clamped,
// and results past December 31 of year 16383 saturate to that date. One item
// is in work at a time. One shared subtractor does the modulo-400 reductions
// of the reference and start years (each holds up to 40 multiples of 400),
// the month-by-month walk (up to about 2200 months for the largest day count)
// and two 7-step weekday reductions. req_tready is high only while no item is
// in work; a finished result waits in the output register without holding up
// the next.
module gregorian_date_add_weekday
   import gda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_month[3:0], start_day[8:4], start_year[22:9], days_to_add[38:23]
   input  logic [39:0] req_tdata,
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_month[3:0], new_day[8:4], new_year[22:9], weekday[25:23]
   output logic [31:0] rsp_tdata,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   gda_ref_type    refs_ff;
   gda_item_type   item;
   gda_status_type status;
   gda_result_type result;
   gda_result_type rsp_ff;
   logic           rsp_valid_ff;
   logic           slot_free;
   logic           start;

   assign item       = gda_item_type'(req_tdata[38:0]);
   assign req_tready = status.idle;
   assign start      = req_tvalid && status.idle;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // Reference date registers
   always_ff @(posedge clock) begin
      if (reset) begin
         refs_ff.day     <= 5'd1;
         refs_ff.month   <= 4'd1;
         refs_ff.year    <= 14'd2000;
         refs_ff.weekday <= 3'd6;
      end else if (csr_valid) begin
         unique case (csr_index)
            RegRefDay:     refs_ff.day     <= csr_wdata[4:0];
            RegRefMonth:   refs_ff.month   <= csr_wdata[3:0];
            RegRefYear:    refs_ff.year    <= csr_wdata;
            RegRefWeekday: refs_ff.weekday <= csr_wdata[2:0];
            default:       ;
         endcase
      end
   end

   gda_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item      (item),
      .refs      (refs_ff),
      .slot_free (slot_free),
      .status    (status),
      .result    (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (slot_free)
         rsp_valid_ff <= status.res_valid;
   end

   always_ff @(posedge clock) begin
      if (slot_free && status.res_valid)
         rsp_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff};

endmodule
